// ----- rtl/dlg_pkg.sv -----
// Shared types, codes and helpers for the dense layer gradient / SGD core.
package dlg_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int VAL_W = 32;
  localparam int MUL_W = 33;
  localparam int DIV_W = 40;
  localparam int DEN_W = 16;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [6:0]  ROWS_RST = 7'd64;
  localparam logic [6:0]  COLS_RST = 7'd64;
  localparam logic [15:0] RATE_RST = 16'd655;
  localparam logic [23:0] REG_RST  = 24'd0;

  typedef enum logic [2:0] {
    CMD_WR_W    = 3'd0,
    CMD_WR_B    = 3'd1,
    CMD_PREV    = 3'd2,
    CMD_DELTA   = 3'd3,
    CMD_DESCEND = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_RD_W    = 3'd6,
    CMD_RD_B    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_ZERO_T = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_RATE = 2'd2,
    CFG_REG  = 2'd3
  } cfg_idx_e;

  // divider request: magnitude, sign of the true numerator, divisor
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // {clip, value}
  function automatic logic [32:0] sat32(input logic signed [47:0] v);
    logic [32:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < 48'shFFFF_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- rtl/dlg_if.sv -----
// Valid/ready channel interfaces: input items, result items, register writes.
interface dlg_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] value;
  logic [15:0]        batch_count;
  modport source (output valid, cmd, row, col, value, batch_count, input ready);
  modport sink   (input valid, cmd, row, col, value, batch_count, output ready);
endinterface

interface dlg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface dlg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dlg_mul.sv -----
// Shared signed multiplier with registered product.
module dlg_mul (
  input  logic                                clk_i,
  input  logic signed [dlg_pkg::MUL_W-1:0]    a_i,
  input  logic signed [dlg_pkg::MUL_W-1:0]    b_i,
  output logic signed [2*dlg_pkg::MUL_W-1:0]  p_o
);
  import dlg_pkg::*;

  logic signed [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/dlg_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, floor-rounded signed result.
module dlg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlg_pkg::div_req_t             req_i,
  output logic                          done_o,
  output logic signed [dlg_pkg::DIV_W:0] res_o
);
  import dlg_pkg::*;

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DIV_W-1:0] quo_q;
  logic [DEN_W:0]   r2;
  logic             ge;
  logic [DIV_W:0]   qext;

  assign r2 = {rem_q, quo_q[DIV_W-1]};
  assign ge = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      cnt_q <= '0;
      neg_q <= req_i.neg;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(r2 - {1'b0, den_q}) : r2[DEN_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // negative numerator: floor = -(q + (rem != 0))
  assign qext   = {1'b0, quo_q};
  assign res_o  = neg_q ? $signed(-(qext + (DIV_W+1)'(rem_q != '0))) : $signed(qext);
  assign done_o = done_q;

endmodule

// ----- rtl/dense_layer_gradient_sgd_core.sv -----
// Top level: stores, sequencer and result register of the gradient / SGD core.
// Weight, bias, gradient and previous-output stores sit in on-chip memories; one
// shared 33x33 multiplier and one 40-step divider do all arithmetic under a
// sequencer, so the core takes one item at a time. A delta item walks the active
// columns (all MAX_COLS columns for the first delta to a row after a clear or
// reset), paced by read, multiply and write-back through the multiplier. A
// descend item runs the divider once for the decay factor, then once per weight
// and once per bias of the active rows. Gradients read as zero after reset and
// clear through per-row valid flags; no clearing pass is run.
module dense_layer_gradient_sgd_core #(
  parameter int MAX_ROWS = dlg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = dlg_pkg::MAX_COLS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  dlg_in_if.sink    in_i,
  dlg_out_if.source out_o,
  dlg_cfg_if.sink   cfg_i
);
  import dlg_pkg::*;

  localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_EXEC   = 20'h00002,
    S_RDW    = 20'h00004,
    S_D_RD   = 20'h00008,
    S_D_MUL  = 20'h00010,
    S_D_WR   = 20'h00020,
    S_D_BIAS = 20'h00040,
    S_Q_M0   = 20'h00080,
    S_Q_M1   = 20'h00100,
    S_Q_DV   = 20'h00200,
    S_E_RD   = 20'h00400,
    S_E_M0   = 20'h00800,
    S_E_M1   = 20'h01000,
    S_E_M2   = 20'h02000,
    S_E_M3   = 20'h04000,
    S_E_DV   = 20'h08000,
    S_B_M0   = 20'h10000,
    S_B_M1   = 20'h20000,
    S_B_DV   = 20'h40000,
    S_FIN    = 20'h80000
  } state_e;

  function automatic logic [AW-1:0] addr(input logic [RIW-1:0] r, input logic [CIW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  state_e st_q, st_d;

  logic [6:0]  rows_q, cols_q;
  logic [15:0] lr_q;
  logic [23:0] reg_q;

  cmd_e        cmd_q;
  logic [5:0]  row_q, col_q;
  logic [31:0] val_q;
  logic [15:0] t_q;

  logic [RCW-1:0]    i_q, i_d, nr;
  logic [CCW-1:0]    j_q, j_d, nc, dlim;
  logic [DIV_W-1:0]  q_q, q_d;
  logic signed [75:0] acc_q, acc_d;
  logic              clip_q, clip_d;
  status_e           stat_q, stat_d;
  logic [31:0]       rd_q, rd_d;
  logic [MAX_ROWS-1:0] rv_q, rv_d, bgv_q, bgv_d;

  logic        out_valid_q;
  logic [31:0] out_rv_q;
  status_e     out_st_q;

  logic in_fire, desc, row_ok, col_ok;
  logic [RIW-1:0] ri, ii, r_idx;
  logic [CIW-1:0] ci, jj;

  // memories
  logic [31:0] w_mem  [MAX_ROWS*MAX_COLS];
  logic [31:0] wg_mem [MAX_ROWS*MAX_COLS];
  logic [31:0] b_mem  [MAX_ROWS];
  logic [31:0] bg_mem [MAX_ROWS];
  logic [31:0] p_mem  [MAX_COLS];
  logic [AW-1:0]  w_a, wg_a;
  logic [CIW-1:0] p_a;
  logic w_we, wg_we, b_we, bg_we, p_we;
  logic [31:0] w_wd, wg_wd, b_wd, bg_wd;
  logic [31:0] w_rd_q, wg_rd_q, b_rd_q, bg_rd_q, p_rd_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  div_req_t                  div_req;
  logic                      div_done;
  logic signed [DIV_W:0]     div_res;

  logic [31:0]        gold, bgold;
  logic [32:0]        dsum, bsum, wdiff, bdiff;
  logic signed [49:0] sn, smag;

  assign in_fire    = in_i.valid & in_i.ready;
  assign in_i.ready = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
      lr_q   <= RATE_RST;
      reg_q  <= REG_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ROWS: rows_q <= cfg_i.data[6:0];
        CFG_COLS: cols_q <= cfg_i.data[6:0];
        CFG_RATE: lr_q   <= cfg_i.data[15:0];
        CFG_REG:  reg_q  <= cfg_i.data;
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (rows_q == '0) nr = RCW'(1);
    else if (int'(rows_q) > MAX_ROWS) nr = RCW'(MAX_ROWS);
    else nr = RCW'(rows_q);
    if (cols_q == '0) nc = CCW'(1);
    else if (int'(cols_q) > MAX_COLS) nc = CCW'(MAX_COLS);
    else nc = CCW'(cols_q);
  end

  assign row_ok = int'(row_q) < int'(nr);
  assign col_ok = int'(col_q) < int'(nc);
  assign ri     = RIW'(row_q);
  assign ci     = CIW'(col_q);
  assign ii     = i_q[RIW-1:0];
  assign jj     = j_q[CIW-1:0];
  assign desc   = (st_q == S_Q_M0) || (st_q == S_Q_M1) || (st_q == S_Q_DV) ||
                  (st_q == S_E_RD) || (st_q == S_E_M0) || (st_q == S_E_M1) ||
                  (st_q == S_E_M2) || (st_q == S_E_M3) || (st_q == S_E_DV) ||
                  (st_q == S_B_M0) || (st_q == S_B_M1) || (st_q == S_B_DV);
  assign r_idx  = desc ? ii : ri;
  assign w_a    = desc ? addr(ii, jj) : addr(ri, ci);
  assign wg_a   = desc ? addr(ii, jj) : addr(ri, jj);
  assign p_a    = (st_q == S_EXEC) ? ci : jj;

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_a] <= w_wd;
    w_rd_q <= w_mem[w_a];
  end
  always_ff @(posedge clk_i) begin
    if (wg_we) wg_mem[wg_a] <= wg_wd;
    wg_rd_q <= wg_mem[wg_a];
  end
  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[r_idx] <= b_wd;
    b_rd_q <= b_mem[r_idx];
  end
  always_ff @(posedge clk_i) begin
    if (bg_we) bg_mem[r_idx] <= bg_wd;
    bg_rd_q <= bg_mem[r_idx];
  end
  always_ff @(posedge clk_i) begin
    if (p_we) p_mem[p_a] <= val_q;
    p_rd_q <= p_mem[p_a];
  end

  dlg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dlg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // gradients of a row not touched since clear read as zero
  assign gold  = rv_q[r_idx]  ? wg_rd_q : '0;
  assign bgold = bgv_q[r_idx] ? bg_rd_q : '0;
  assign dlim  = rv_q[ri] ? nc : CCW'(MAX_COLS);

  assign dsum  = sat32(48'($signed(gold)) +
                       ((j_q < nc) ? 48'($signed(mul_p[65:24])) : 48'sd0));
  assign bsum  = sat32(48'($signed(bgold)) + 48'($signed(val_q)));
  assign wdiff = sat32(48'($signed(acc_q[75:32])) - 48'(div_res));
  assign bdiff = sat32(48'($signed(b_rd_q)) - 48'(div_res));
  // floor(g*rate/2^16), then divided by t: same as floor(g*rate/(t*2^16))
  assign sn    = $signed(mul_p[65:16]);
  assign smag  = sn[49] ? -sn : sn;

  always_comb begin
    st_d    = st_q;
    i_d     = i_q;
    j_d     = j_q;
    q_d     = q_q;
    acc_d   = acc_q;
    clip_d  = clip_q;
    stat_d  = stat_q;
    rd_d    = rd_q;
    rv_d    = rv_q;
    bgv_d   = bgv_q;
    w_we    = 1'b0;
    wg_we   = 1'b0;
    b_we    = 1'b0;
    bg_we   = 1'b0;
    p_we    = 1'b0;
    w_wd    = (st_q == S_EXEC) ? val_q : wdiff[31:0];
    b_wd    = (st_q == S_EXEC) ? val_q : bdiff[31:0];
    wg_wd   = dsum[31:0];
    bg_wd   = bsum[31:0];
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    div_req.den = t_q;

    unique case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          clip_d = 1'b0;
          stat_d = ST_OK;
          rd_d   = '0;
          st_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        st_d = S_FIN;
        unique case (cmd_q)
          CMD_WR_W: if (row_ok && col_ok) w_we = 1'b1; else stat_d = ST_RANGE;
          CMD_WR_B: if (row_ok) b_we = 1'b1; else stat_d = ST_RANGE;
          CMD_PREV: if (col_ok) p_we = 1'b1; else stat_d = ST_RANGE;
          CMD_DELTA: begin
            if (row_ok) begin
              j_d  = '0;
              st_d = S_D_RD;
            end else begin
              stat_d = ST_RANGE;
            end
          end
          CMD_DESCEND: begin
            if (t_q == '0) begin
              stat_d = ST_ZERO_T;
            end else begin
              i_d  = '0;
              j_d  = '0;
              st_d = S_Q_M0;
            end
          end
          CMD_CLEAR: begin
            rv_d  = '0;
            bgv_d = '0;
          end
          CMD_RD_W: if (row_ok && col_ok) st_d = S_RDW; else stat_d = ST_RANGE;
          CMD_RD_B: if (row_ok) st_d = S_RDW; else stat_d = ST_RANGE;
          default: ;
        endcase
      end
      S_RDW: begin
        rd_d = (cmd_q == CMD_RD_W) ? w_rd_q : b_rd_q;
        st_d = S_FIN;
      end
      S_D_RD: st_d = S_D_MUL;
      S_D_MUL: begin
        mul_a = MUL_W'($signed(p_rd_q));
        mul_b = MUL_W'($signed(val_q));
        st_d  = S_D_WR;
      end
      S_D_WR: begin
        wg_we  = 1'b1;
        clip_d = clip_q | dsum[32];
        if (j_q + CCW'(1) == dlim) begin
          st_d = S_D_BIAS;
        end else begin
          j_d  = j_q + CCW'(1);
          st_d = S_D_RD;
        end
      end
      S_D_BIAS: begin
        bg_we     = 1'b1;
        clip_d    = clip_q | bsum[32];
        bgv_d[ri] = 1'b1;
        rv_d[ri]  = 1'b1;
        st_d      = S_FIN;
      end
      S_Q_M0: begin
        mul_a = MUL_W'(lr_q);
        mul_b = MUL_W'(reg_q);
        st_d  = S_Q_M1;
      end
      S_Q_M1: begin
        div_req.start = 1'b1;
        div_req.num   = mul_p[DIV_W-1:0];
        st_d          = S_Q_DV;
      end
      S_Q_DV: begin
        if (div_done) begin
          q_d  = div_res[DIV_W-1:0];
          st_d = S_E_RD;
        end
      end
      S_E_RD: st_d = S_E_M0;
      S_E_M0: begin
        mul_a = MUL_W'($signed(w_rd_q));
        mul_b = MUL_W'(q_q[31:0]);
        st_d  = S_E_M1;
      end
      S_E_M1: begin
        // w*(2^32 - q) = w*2^32 - w*q_lo - w*q_hi*2^32
        acc_d = $signed({{12{w_rd_q[31]}}, w_rd_q, 32'b0}) - 76'(mul_p);
        mul_a = MUL_W'($signed(w_rd_q));
        mul_b = MUL_W'(q_q[DIV_W-1:32]);
        st_d  = S_E_M2;
      end
      S_E_M2: begin
        acc_d = acc_q - $signed({mul_p[43:0], 32'b0});
        mul_a = MUL_W'($signed(gold));
        mul_b = MUL_W'(lr_q);
        st_d  = S_E_M3;
      end
      S_E_M3: begin
        div_req.start = 1'b1;
        div_req.neg   = sn[49];
        div_req.num   = smag[DIV_W-1:0];
        st_d          = S_E_DV;
      end
      S_E_DV: begin
        if (div_done) begin
          w_we   = 1'b1;
          clip_d = clip_q | wdiff[32];
          if (j_q + CCW'(1) == nc) begin
            j_d  = '0;
            st_d = S_B_M0;
          end else begin
            j_d  = j_q + CCW'(1);
            st_d = S_E_RD;
          end
        end
      end
      S_B_M0: begin
        mul_a = MUL_W'($signed(bgold));
        mul_b = MUL_W'(lr_q);
        st_d  = S_B_M1;
      end
      S_B_M1: begin
        div_req.start = 1'b1;
        div_req.neg   = sn[49];
        div_req.num   = smag[DIV_W-1:0];
        st_d          = S_B_DV;
      end
      S_B_DV: begin
        if (div_done) begin
          b_we   = 1'b1;
          clip_d = clip_q | bdiff[32];
          if (i_q + RCW'(1) == nr) begin
            st_d = S_FIN;
          end else begin
            i_d  = i_q + RCW'(1);
            st_d = S_E_RD;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      rv_q        <= '0;
      bgv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      rv_q  <= rv_d;
      bgv_q <= bgv_d;
      if (st_q == S_FIN && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(in_i.cmd);
      row_q <= in_i.row;
      col_q <= in_i.col;
      val_q <= in_i.value;
      t_q   <= in_i.batch_count;
    end
    i_q    <= i_d;
    j_q    <= j_d;
    q_q    <= q_d;
    acc_q  <= acc_d;
    clip_q <= clip_d;
    stat_q <= stat_d;
    rd_q   <= rd_d;
    if (st_q == S_FIN && (!out_valid_q || out_o.ready)) begin
      out_rv_q <= rd_q;
      out_st_q <= clip_q ? ST_SAT : stat_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_rv_q;
  assign out_o.status     = out_st_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (st_q == S_EXEC))
    else $error("item accepted but sequencer did not start");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == S_FIN))
    else $error("result raised outside the finish step");

  a_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.cmd == CMD_CLEAR) |-> ##2 (rv_q == '0 && bgv_q == '0))
    else $error("clear item left gradient flags set");

endmodule

// ----- bench/dlg_checker.sv -----
// Checker: watches the item, result and register channels, predicts results and compares.
`timescale 1ns / 100ps

module dlg_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dlg_in_if    in_b,
  dlg_out_if   out_b,
  dlg_cfg_if   cfg_b,
  output int   fail_count_o,
  output int   pending_o
);
  import dlg_pkg::*;

  typedef struct packed {
    logic [31:0] rd;
    status_e     st;
  } result_t;

  result_t expected_q[$];

  int weights [4096];
  int biases  [64];
  int wgrads  [4096];
  int bgrads  [64];
  int prevs   [64];

  logic [6:0]  rows_cfg;
  logic [6:0]  cols_cfg;
  logic [15:0] rate_cfg;
  logic [23:0] reg_cfg;
  int          errs;

  function automatic int clip32(input longint v, inout bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic int clamp_dim(input logic [6:0] v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic result_t predict_update(input cmd_e c, input int r, input int cl,
                                             input longint v, input longint t);
    result_t res;
    int      nr;
    int      nc;
    bit      row_ok;
    bit      col_ok;
    bit      clip;
    longint  q;
    longint  f;
    longint  fh;
    longint  fl;
    longint  den;
    longint  wv;
    longint  dec;
    longint  stp;
    int      k;
    nr = clamp_dim(rows_cfg);
    nc = clamp_dim(cols_cfg);
    row_ok = r < nr;
    col_ok = cl < nc;
    clip = 1'b0;
    res.rd = '0;
    res.st = ST_OK;
    case (c)
      CMD_WR_W: begin
        if (row_ok && col_ok) weights[r*64+cl] = int'(v);
        else res.st = ST_RANGE;
      end
      CMD_WR_B: begin
        if (row_ok) biases[r] = int'(v);
        else res.st = ST_RANGE;
      end
      CMD_PREV: begin
        if (col_ok) prevs[cl] = int'(v);
        else res.st = ST_RANGE;
      end
      CMD_DELTA: begin
        if (!row_ok) begin
          res.st = ST_RANGE;
        end else begin
          for (int j = 0; j < nc; j++) begin
            k = r*64 + j;
            wgrads[k] = clip32(longint'(wgrads[k]) + ((longint'(prevs[j]) * v) >>> 24), clip);
          end
          bgrads[r] = clip32(longint'(bgrads[r]) + v, clip);
          if (clip) res.st = ST_SAT;
        end
      end
      CMD_DESCEND: begin
        if (t == 0) begin
          res.st = ST_ZERO_T;
        end else begin
          q = (longint'(rate_cfg) * longint'(reg_cfg)) / t;
          f = 64'sd4294967296 - q;
          fh = f >>> 32;
          fl = f - (fh <<< 32);
          den = t * 65536;
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              k = i*64 + j;
              wv = longint'(weights[k]);
              dec = wv * fh + ((wv * fl) >>> 32);
              stp = floor_quot(longint'(wgrads[k]) * longint'(rate_cfg), den);
              weights[k] = clip32(dec - stp, clip);
            end
            stp = floor_quot(longint'(bgrads[i]) * longint'(rate_cfg), den);
            biases[i] = clip32(longint'(biases[i]) - stp, clip);
          end
          if (clip) res.st = ST_SAT;
        end
      end
      CMD_CLEAR: begin
        foreach (wgrads[i]) wgrads[i] = 0;
        foreach (bgrads[i]) bgrads[i] = 0;
      end
      CMD_RD_W: begin
        if (row_ok && col_ok) res.rd = weights[r*64+cl];
        else res.st = ST_RANGE;
      end
      default: begin
        if (row_ok) res.rd = biases[r];
        else res.st = ST_RANGE;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      expected_q.delete();
      foreach (wgrads[i]) wgrads[i] = 0;
      foreach (bgrads[i]) bgrads[i] = 0;
      rows_cfg = ROWS_RST;
      cols_cfg = COLS_RST;
      rate_cfg = RATE_RST;
      reg_cfg  = REG_RST;
      errs = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_b.valid && cfg_b.ready) begin
        case (cfg_idx_e'(cfg_b.index))
          CFG_ROWS: rows_cfg = cfg_b.data[6:0];
          CFG_COLS: cols_cfg = cfg_b.data[6:0];
          CFG_RATE: rate_cfg = cfg_b.data[15:0];
          default:  reg_cfg  = cfg_b.data;
        endcase
      end
      if (in_b.valid && in_b.ready) begin
        expected_q.push_back(predict_update(cmd_e'(in_b.cmd), int'(in_b.row), int'(in_b.col),
                                            longint'(in_b.value),
                                            longint'({48'b0, in_b.batch_count})));
      end
      if (out_b.valid && out_b.ready) begin
        if (expected_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result item: rd %h st %0d",
                                   out_b.read_value, out_b.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_b.read_value !== exp_r.rd || out_b.status !== exp_r.st) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected rd %h st %0d, got rd %h st %0d",
                       exp_r.rd, exp_r.st, out_b.read_value, out_b.status);
          end
        end
      end
      fail_count_o <= errs;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- bench/dense_layer_gradient_sgd_core_tb.sv -----
// Testbench top: clock, reset, item and register stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module dense_layer_gradient_sgd_core_tb;
  import dlg_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   idle_cycles = 0;

  // stimulus-side view of the active region and of what has been written
  int   act_rows;
  int   act_cols;
  bit   w_done [4096];
  bit   b_done [64];
  bit   p_done [64];
  int   burst_left;
  bit   quiet;

  dlg_in_if  in_b ();
  dlg_out_if out_b ();
  dlg_cfg_if cfg_b ();

  dense_layer_gradient_sgd_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_b),
    .out_o  (out_b),
    .cfg_i  (cfg_b)
  );

  dlg_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_b         (in_b),
    .out_b        (out_b),
    .cfg_b        (cfg_b),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver stall pattern: runs of always-ready, random, and long stalls
  initial begin
    int mode;
    int run;
    out_b.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      run = $urandom_range(40, 300);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          0: out_b.ready = 1'b1;
          1: out_b.ready = $urandom_range(0, 1);
          default: out_b.ready = ($urandom_range(0, 15) != 0) ? out_b.ready
                                                              : ~out_b.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_b.valid && in_b.ready) || (out_b.valid && out_b.ready) ||
        (cfg_b.valid && cfg_b.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int clamp_dim(input int v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : v;
  endfunction

  task automatic send_item(input cmd_e c, input int r, input int cl,
                           input logic [31:0] v, input logic [15:0] t);
    int gap;
    if (burst_left == 0) begin
      in_b.valid = 1'b0;
      gap = quiet ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 5));
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
    end
    burst_left--;
    in_b.valid = 1'b1;
    in_b.cmd = c;
    in_b.row = r[5:0];
    in_b.col = cl[5:0];
    in_b.value = v;
    in_b.batch_count = t;
    do @(posedge clk); while (!in_b.ready);
    @(negedge clk);
    if (c == CMD_WR_W && r < act_rows && cl < act_cols) w_done[r*64+cl] = 1'b1;
    if (c == CMD_WR_B && r < act_rows) b_done[r] = 1'b1;
    if (c == CMD_PREV && cl < act_cols) p_done[cl] = 1'b1;
  endtask

  task automatic drain();
    in_b.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int data);
    drain();
    repeat (8) @(negedge clk);
    cfg_b.valid = 1'b1;
    cfg_b.index = idx;
    cfg_b.data = data[23:0];
    do @(posedge clk); while (!cfg_b.ready);
    @(negedge clk);
    cfg_b.valid = 1'b0;
    if (idx == CFG_ROWS) act_rows = clamp_dim(data & 8'h7F);
    if (idx == CFG_COLS) act_cols = clamp_dim(data & 8'h7F);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_index(input int n);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // every entry that a delta or descend will read gets a value first
  task automatic fill_region();
    for (int i = 0; i < act_rows; i++) begin
      for (int j = 0; j < act_cols; j++)
        if (!w_done[i*64+j]) send_item(CMD_WR_W, i, j, rand_value(), 16'($urandom));
      if (!b_done[i]) send_item(CMD_WR_B, i, 0, rand_value(), 16'($urandom));
    end
    for (int j = 0; j < act_cols; j++)
      if (!p_done[j]) send_item(CMD_PREV, 0, j, rand_value(), 16'($urandom));
  endtask

  task automatic random_item();
    int pick;
    int dsc;
    dsc = (act_rows * act_cols <= 32) ? 8 : 2;
    pick = $urandom_range(0, 76 + dsc);
    if (pick < 10)       send_item(CMD_WR_W, rand_index(act_rows), rand_index(act_cols),
                                   rand_value(), 16'($urandom));
    else if (pick < 15)  send_item(CMD_WR_B, rand_index(act_rows), $urandom_range(0, 63),
                                   rand_value(), 16'($urandom));
    else if (pick < 25)  send_item(CMD_PREV, $urandom_range(0, 63), rand_index(act_cols),
                                   rand_value(), 16'($urandom));
    else if (pick < 50)  send_item(CMD_DELTA, rand_index(act_rows), $urandom_range(0, 63),
                                   rand_value(), 16'($urandom));
    else if (pick < 54)  send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom, 16'($urandom));
    else if (pick < 64)  send_item(CMD_RD_W, rand_index(act_rows), rand_index(act_cols),
                                   $urandom, 16'($urandom));
    else if (pick < 69)  send_item(CMD_RD_B, rand_index(act_rows), $urandom_range(0, 63),
                                   $urandom, 16'($urandom));
    else if (pick < 77)  send_item(CMD_DELTA, rand_index(act_rows), 0,
                                   $urandom_range(0, 32'h0100_0000), 16'($urandom));
    else                 send_item(CMD_DESCEND, $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom, rand_count());
    if ($urandom_range(0, 199) == 0) drain();
  endtask

  task automatic run_phase(input int rows, input int cols, input int rate, input int l2,
                           input int n);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_RATE, rate);
    write_reg(CFG_REG, l2);
    fill_region();
    repeat (n) random_item();
  endtask

  initial begin
    in_b.valid = 1'b0;
    in_b.cmd = CMD_WR_W;
    in_b.row = '0;
    in_b.col = '0;
    in_b.value = '0;
    in_b.batch_count = '0;
    cfg_b.valid = 1'b0;
    cfg_b.index = CFG_ROWS;
    cfg_b.data = '0;
    act_rows = 64;
    act_cols = 64;
    burst_left = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes under the reset sizes
    send_item(CMD_WR_W, 0, 0, 32'h7FFF_FFFF, 16'h0000);
    send_item(CMD_WR_W, 63, 63, 32'h8000_0000, 16'hFFFF);
    send_item(CMD_RD_W, 0, 0, '0, '0);
    send_item(CMD_RD_W, 63, 63, '0, '0);
    send_item(CMD_WR_B, 0, 0, 32'h8000_0000, '0);
    send_item(CMD_WR_B, 63, 0, 32'h7FFF_FFFF, '0);
    send_item(CMD_RD_B, 63, 0, '0, '0);
    send_item(CMD_PREV, 0, 63, 32'h0100_0000, '0);
    send_item(CMD_CLEAR, 0, 0, '0, '0);
    send_item(CMD_DESCEND, 0, 0, '0, 16'd0);

    // one by one region: out of range for every indexed operation, then saturation
    write_reg(CFG_ROWS, 1);
    write_reg(CFG_COLS, 1);
    fill_region();
    send_item(CMD_WR_W, 0, 1, '1, '0);
    send_item(CMD_WR_B, 1, 0, '1, '0);
    send_item(CMD_PREV, 0, 63, '1, '0);
    send_item(CMD_DELTA, 63, 0, '1, '0);
    send_item(CMD_RD_W, 1, 0, '0, '0);
    send_item(CMD_RD_B, 63, 0, '0, '0);
    send_item(CMD_PREV, 0, 0, 32'h7FFF_FFFF, '0);
    send_item(CMD_DELTA, 0, 0, 32'h7FFF_FFFF, '0);
    send_item(CMD_DELTA, 0, 0, 32'h7FFF_FFFF, '0);
    send_item(CMD_DESCEND, 0, 0, '0, 16'd1);
    send_item(CMD_RD_W, 0, 0, '0, '0);
    send_item(CMD_RD_B, 0, 0, '0, '0);

    run_phase(1, 1, 0, 0, 150);
    run_phase(0, 0, 65535, 24'hFFFFFF, 200);
    run_phase(4, 8, 655, 0, 350);
    run_phase(127, 2, 1000, 65536, 200);
    run_phase(2, 127, 30000, 300, 250);
    run_phase(3, 5, 655, 24'h5A5A5A, 300);

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dlg_pkg.sv
rtl/dlg_if.sv
rtl/dlg_mul.sv
rtl/dlg_div.sv
rtl/dense_layer_gradient_sgd_core.sv
bench/dlg_checker.sv
bench/dense_layer_gradient_sgd_core_tb.sv
